### src/isu_pkg.sv
package isu_pkg;

  // lattice geometry: side is a power of two so a site address is {row, col}
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned SIDE   = 1 << IDX_W;
  localparam int unsigned SITES  = SIDE * SIDE;
  localparam int unsigned ADDR_W = 2 * IDX_W;

  localparam int unsigned THR_W  = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DE_W   = 5;
  localparam int unsigned MAG_W  = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DE4 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_DE8 = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(65536);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SITE,
    ST_UP,
    ST_DN,
    ST_LF,
    ST_RT,
    ST_EVAL,
    ST_LOAD
  } state_e;

  typedef enum logic [2:0] {
    ADDR_SITE,
    ADDR_UP,
    ADDR_DN,
    ADDR_LF,
    ADDR_RT,
    ADDR_CLR
  } addr_sel_e;

  typedef struct packed {
    logic      latch;
    addr_sel_e addr_sel;
    logic      cur_en;
    logic      acc_clr;
    logic      acc_en;
    logic      eval_upd;
    logic      eval_load;
    logic      clr_wr;
    logic      clr_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_load;
  } dp_status_t;

endpackage

### src/isu_ctrl.sv
module isu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  isu_pkg::dp_status_t status_i,
  output isu_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o
);
  import isu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_SITE;
      ST_SITE:  state_d = status_i.is_load ? ST_LOAD : ST_UP;
      ST_UP:    state_d = ST_DN;
      ST_DN:    state_d = ST_LF;
      ST_LF:    state_d = ST_RT;
      ST_RT:    state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_IDLE;
      ST_LOAD:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_SITE;
    busy_o         = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.addr_sel = ADDR_CLR;
        cmd_o.clr_wr   = 1'b1;
        cmd_o.clr_inc  = 1'b1;
      end
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start_i;
      end
      ST_SITE: cmd_o.addr_sel = ADDR_SITE;
      ST_UP: begin
        cmd_o.addr_sel = ADDR_UP;
        cmd_o.cur_en   = 1'b1;
        cmd_o.acc_clr  = 1'b1;
      end
      ST_DN: begin
        cmd_o.addr_sel = ADDR_DN;
        cmd_o.acc_en   = 1'b1;
      end
      ST_LF: begin
        cmd_o.addr_sel = ADDR_LF;
        cmd_o.acc_en   = 1'b1;
      end
      ST_RT: begin
        cmd_o.addr_sel = ADDR_RT;
        cmd_o.acc_en   = 1'b1;
      end
      ST_EVAL: cmd_o.eval_upd  = 1'b1;
      ST_LOAD: cmd_o.eval_load = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

### src/isu_dpath.sv
module isu_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  isu_pkg::ctrl_cmd_t                cmd_i,
  output isu_pkg::dp_status_t               status_o,
  input  logic                              op_cmd_i,
  input  logic [isu_pkg::IDX_W-1:0]         row_i,
  input  logic [isu_pkg::IDX_W-1:0]         col_i,
  input  logic                              spin_bit_i,
  input  logic [isu_pkg::FRAC_W-1:0]        random_fraction_i,
  input  logic                              cfg_we_i,
  input  logic [isu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [isu_pkg::THR_W-1:0]         cfg_data_i,
  output logic                              done_o,
  output logic                              site_spin_o,
  output logic                              flipped_o,
  output logic signed [isu_pkg::DE_W-1:0]   energy_change_o,
  output logic signed [isu_pkg::MAG_W-1:0]  magnetization_sum_o
);
  import isu_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SIDE - 1);

  // threshold registers
  logic [THR_W-1:0] th4_q, th8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th4_q <= THRESH_RESET;
      th8_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESH_DE4: th4_q <= cfg_data_i;
        REG_THRESH_DE8: th8_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand latch
  logic              cmd_q, sbit_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic [FRAC_W-1:0] frac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= op_cmd_i;
      row_q  <= row_i;
      col_q  <= col_i;
      sbit_q <= spin_bit_i;
      frac_q <= random_fraction_i;
    end
  end

  assign status_o.is_load = (cmd_q == CMD_LOAD);

  // clearing pass counter
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_inc) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign status_o.clr_last = (clr_q == ADDR_W'(SITES - 1));

  // neighbor addresses with toroidal wrap
  logic [IDX_W-1:0] up_row, dn_row, lf_col, rt_col;
  assign up_row = (row_q == '0)  ? LAST : row_q - IDX_W'(1);
  assign dn_row = (row_q == LAST) ? '0  : row_q + IDX_W'(1);
  assign lf_col = (col_q == '0)  ? LAST : col_q - IDX_W'(1);
  assign rt_col = (col_q == LAST) ? '0  : col_q + IDX_W'(1);

  logic [ADDR_W-1:0] addr;
  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_SITE: addr = {row_q, col_q};
      ADDR_UP:   addr = {up_row, col_q};
      ADDR_DN:   addr = {dn_row, col_q};
      ADDR_LF:   addr = {row_q, lf_col};
      ADDR_RT:   addr = {row_q, rt_col};
      ADDR_CLR:  addr = clr_q;
      default:   addr = {row_q, col_q};
    endcase
  end

  // single-port spin memory
  logic mem_q [SITES];
  logic rdata_q;
  logic mem_we, mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr];
  end

  // current spin and neighbor count
  logic       cur_q;
  logic [2:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_en) begin
      cur_q <= rdata_q;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + 3'(rdata_q);
    end
  end

  // energy change and acceptance
  logic [2:0]            ones;
  logic signed [5:0]     t;
  logic signed [DE_W-1:0] de_raw, de;
  logic                  propose, accept, lt4, lt8;

  assign ones    = acc_q + 3'(rdata_q);
  assign t       = $signed({1'b0, ones, 2'b00}) - 6'sd8;
  assign de_raw  = sbit_q ? DE_W'(-t) : DE_W'(t);
  assign propose = (sbit_q != cur_q);
  assign de      = propose ? de_raw : '0;
  assign lt4     = ({1'b0, frac_q} < th4_q);
  assign lt8     = ({1'b0, frac_q} < th8_q);

  always_comb begin
    if (de_raw[DE_W-1] || (de_raw == '0)) begin
      accept = 1'b1;
    end else if (de_raw == DE_W'(4)) begin
      accept = lt4;
    end else begin
      accept = lt8;
    end
  end

  logic flip, old_spin, changes;
  assign flip     = cmd_i.eval_upd && propose && accept;
  assign old_spin = cmd_i.eval_load ? rdata_q : cur_q;
  assign changes  = (cmd_i.eval_load || flip) && (sbit_q != old_spin);

  assign mem_we    = cmd_i.clr_wr || cmd_i.eval_load || flip;
  assign mem_wdata = cmd_i.clr_wr ? 1'b0 : sbit_q;

  // running magnetization
  logic signed [MAG_W-1:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= -MAG_W'(SITES);
    end else if (changes) begin
      mag_q <= sbit_q ? mag_q + MAG_W'(2) : mag_q - MAG_W'(2);
    end
  end

  // result registers
  logic                   done_q, spin_q, flipped_q;
  logic signed [DE_W-1:0] de_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.eval_upd || cmd_i.eval_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_load) begin
      spin_q    <= sbit_q;
      flipped_q <= 1'b0;
      de_q      <= '0;
    end else if (cmd_i.eval_upd) begin
      spin_q    <= flip ? sbit_q : cur_q;
      flipped_q <= flip;
      de_q      <= de;
    end
  end

  assign done_o              = done_q;
  assign site_spin_o         = spin_q;
  assign flipped_o           = flipped_q;
  assign energy_change_o     = de_q;
  assign magnetization_sum_o = mag_q;

endmodule

### src/ising_metropolis_site_update.sv
// channel   direction  ports                                         handshake
// command   in         cmd_i row_i col_i spin_bit_i random_fraction_i start && !busy
// result    out        site_spin_o flipped_o energy_change_o
//                      magnetization_sum_o                           done_o, one cycle
// config    in         cfg_idx_i cfg_data_i                          cfg_we_i
//
// update items step through site, up, dn, lf, rt, eval; load items through site, load;
// the order is set by the single-port spin memory: site, four neighbors, write-back
// the result strobe comes in the cycle where busy has dropped again
// after reset a clearing pass zeroes all 4096 lattice sites, busy stays high
// the receiver cannot stall; config writes are taken at any time
module ising_metropolis_site_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic [isu_pkg::IDX_W-1:0]         row_i,
  input  logic [isu_pkg::IDX_W-1:0]         col_i,
  input  logic                              spin_bit_i,
  input  logic [isu_pkg::FRAC_W-1:0]        random_fraction_i,
  input  logic                              cfg_we_i,
  input  logic [isu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [isu_pkg::THR_W-1:0]         cfg_data_i,
  output logic                              done_o,
  output logic                              site_spin_o,
  output logic                              flipped_o,
  output logic signed [isu_pkg::DE_W-1:0]   energy_change_o,
  output logic signed [isu_pkg::MAG_W-1:0]  magnetization_sum_o
);
  import isu_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: clear pass, then per item site read, neighbor reads and evaluate, or load
  isu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // lattice memory, neighbor count, acceptance test and magnetization
  isu_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .op_cmd_i            (cmd_i),
    .row_i               (row_i),
    .col_i               (col_i),
    .spin_bit_i          (spin_bit_i),
    .random_fraction_i   (random_fraction_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .done_o              (done_o),
    .site_spin_o         (site_spin_o),
    .flipped_o           (flipped_o),
    .energy_change_o     (energy_change_o),
    .magnetization_sum_o (magnetization_sum_o)
  );

`ifndef SYNTHESIS
  // a result only appears once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // every result follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without preceding work");

  // spins move the total in steps of two from an even start
  assert property (@(posedge clk_i) disable iff (!rst_ni) !magnetization_sum_o[0])
    else $error("magnetization sum became odd");
`endif

endmodule
